// ===== hdl/sbc_pkg.sv =====
// Shared types and constants for the sphere/box collision checker.
// No dependencies; used by every module in hdl/.
package sbc_pkg;

  localparam int MAX_OBSTACLES = 32;
  localparam int COORD_WIDTH   = 24;
  localparam int IDX_W         = $clog2(MAX_OBSTACLES);
  localparam int CNT_W         = $clog2(MAX_OBSTACLES + 1);
  localparam int RAD_W         = 23;
  localparam int SQ_W          = 2 * COORD_WIDTH;
  localparam int SUM_W         = SQ_W + 2;
  localparam int LINK_W        = 6;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef enum logic [2:0] {
    KIND_HIT     = 3'd0,
    KIND_ACCEPT  = 3'd1,
    KIND_INVALID = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_DONE    = 3'd4
  } kind_t;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TEST = 1'b1;

  typedef struct packed {
    logic              action;
    coord_t            pos_x;
    coord_t            pos_y;
    coord_t            pos_z;
    coord_t            max_x;
    coord_t            max_y;
    coord_t            max_z;
    logic [LINK_W-1:0] link_number;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [4:0]        obstacle_index;
    logic [LINK_W-1:0] link_out;
    coord_t            closest_x;
    coord_t            closest_y;
    coord_t            closest_z;
    logic              hit_any;
    logic              last;
  } out_item_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  // box entering the evaluator
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    box_t             box;
  } feed_t;

  // evaluator verdict for one box
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    coord_t           cx;
    coord_t           cy;
    coord_t           cz;
  } verdict_t;

endpackage

// ===== hdl/sbc_cell.sv =====
// One obstacle slot of the rotating box chain.
// Depends on sbc_pkg.
module sbc_cell
  import sbc_pkg::*;
(
  input  logic clk,
  input  logic load,
  input  box_t load_box,
  input  logic shift,
  input  box_t neighbor_box,
  output box_t box
);

  // load from the add path, or take the neighbor's box during a sweep
  always_ff @(posedge clk) begin
    if (load) begin
      box <= load_box;
    end else if (shift) begin
      box <= neighbor_box;
    end
  end

endmodule

// ===== hdl/sbc_eval.sv =====
// Clamp, square and compare pipeline for one box per cycle while adv is high.
// Depends on sbc_pkg.
module sbc_eval
  import sbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  feed_t                  feed,
  input  coord_t                 px,
  input  coord_t                 py,
  input  coord_t                 pz,
  input  logic [2*RAD_W-1:0]     r_sq,
  output verdict_t               verdict,
  output logic                   busy
);

  logic                 s1_valid;
  logic [IDX_W-1:0]     s1_idx;
  coord_t               s1_cx, s1_cy, s1_cz;
  logic [COORD_WIDTH-1:0] s1_dx, s1_dy, s1_dz;
  logic                 s2_valid;
  logic [IDX_W-1:0]     s2_idx;
  coord_t               s2_cx, s2_cy, s2_cz;
  logic [SQ_W-1:0]      s2_qx, s2_qy, s2_qz;
  coord_t               cx, cy, cz;
  logic [SUM_W-1:0]     sum;

  function automatic coord_t clamp(coord_t v, coord_t lo, coord_t hi);
    coord_t r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] absdiff(coord_t a, coord_t b);
    logic signed [COORD_WIDTH:0] d;
    d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
    if (d[COORD_WIDTH]) d = -d;
    return d[COORD_WIDTH-1:0];
  endfunction

  assign cx = clamp(px, feed.box.min_x, feed.box.max_x);
  assign cy = clamp(py, feed.box.min_y, feed.box.max_y);
  assign cz = clamp(pz, feed.box.min_z, feed.box.max_z);

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= feed.valid;
      s2_valid <= s1_valid;
    end
  end

  // stage 1: clamped point and distances; stage 2: squares
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx <= feed.idx;
      s1_cx  <= cx;
      s1_cy  <= cy;
      s1_cz  <= cz;
      s1_dx  <= absdiff(px, cx);
      s1_dy  <= absdiff(py, cy);
      s1_dz  <= absdiff(pz, cz);
      s2_idx <= s1_idx;
      s2_cx  <= s1_cx;
      s2_cy  <= s1_cy;
      s2_cz  <= s1_cz;
      s2_qx  <= s1_dx * s1_dx;
      s2_qy  <= s1_dy * s1_dy;
      s2_qz  <= s1_dz * s1_dz;
    end
  end

  // sum and compare against the squared radius
  assign sum = {2'b00, s2_qx} + {2'b00, s2_qy} + {2'b00, s2_qz};
  assign verdict.hit = s2_valid && (sum <= {{(SUM_W-2*RAD_W){1'b0}}, r_sq});
  assign verdict.idx = s2_idx;
  assign verdict.cx  = s2_cx;
  assign verdict.cy  = s2_cy;
  assign verdict.cz  = s2_cz;
  assign busy = s1_valid | s2_valid;

endmodule

// ===== hdl/sphere_box_collision_checker.sv =====
// Top level: box chain, evaluator and query sequencer with output register.
// Depends on sbc_pkg, sbc_cell, sbc_eval.
//
// channel | direction | handshake         | payload
// in      | in        | in_valid/in_stall | in_item (in_item_t)
// out     | out       | out_valid/out_stall | out_item (out_item_t)
// cfg     | in        | cfg_valid/cfg_ready | cfg_data (safety radius)
//
// An add's result item is registered when the add is accepted. A test sweeps
// all 32 slots of the box chain, one per cycle while the output is not stalled,
// then drains the two-stage evaluator before the query done item is registered;
// the next item can enter once the sequencer is back in idle.
// Output stalls freeze the sweep and the evaluator together.
// Synchronous reset empties the table and sets the radius to 1024.
module sphere_box_collision_checker
  import sbc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [RAD_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   box_count;
  logic [CNT_W-1:0]   step;
  logic [RAD_W-1:0]   radius;
  logic [2*RAD_W-1:0] r_sq;
  coord_t             qx, qy, qz;
  logic [LINK_W-1:0]  link;
  logic               hit_seen;
  logic               adv;
  logic               accept;
  logic               bad_box;
  logic               shift;
  logic               busy;
  box_t               new_box;
  box_t               boxes [MAX_OBSTACLES];
  feed_t              feed;
  verdict_t           verdict;
  out_item_t          add_res;

  assign adv       = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || !adv;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign shift     = (state == ST_RUN) && adv;
  assign bad_box   = (in_item.pos_x > in_item.max_x) || (in_item.pos_y > in_item.max_y)
                   || (in_item.pos_z > in_item.max_z);

  assign new_box = '{min_x: in_item.pos_x, min_y: in_item.pos_y, min_z: in_item.pos_z,
                     max_x: in_item.max_x, max_y: in_item.max_y, max_z: in_item.max_z};

  // rotating chain of box slots; slot 0 feeds the evaluator
  for (genvar i = 0; i < MAX_OBSTACLES; i++) begin : g_cell
    sbc_cell u_cell (
      .clk          (clk),
      .load         (accept && in_item.action == ACT_ADD && !bad_box
                     && box_count == CNT_W'(i)),
      .load_box     (new_box),
      .shift        (shift),
      .neighbor_box (boxes[(i + 1) % MAX_OBSTACLES]),
      .box          (boxes[i])
    );
  end

  assign feed.valid = (state == ST_RUN) && (step < box_count);
  assign feed.idx   = step[IDX_W-1:0];
  assign feed.box   = boxes[0];

  sbc_eval u_eval (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .feed    (feed),
    .px      (qx),
    .py      (qy),
    .pz      (qz),
    .r_sq    (r_sq),
    .verdict (verdict),
    .busy    (busy)
  );

  // radius register and its square
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RAD_W'(1024);
    end else if (cfg_valid) begin
      radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    r_sq <= radius * radius;
  end

  // query point capture
  always_ff @(posedge clk) begin
    if (accept && in_item.action == ACT_TEST) begin
      qx   <= in_item.pos_x;
      qy   <= in_item.pos_y;
      qz   <= in_item.pos_z;
      link <= in_item.link_number;
    end
  end

  // result item for an add; an inverted box wins over a full table
  always_comb begin
    add_res      = '0;
    add_res.last = 1'b1;
    if (bad_box) begin
      add_res.kind = KIND_INVALID;
    end else if (box_count >= CNT_W'(MAX_OBSTACLES)) begin
      add_res.kind = KIND_FULL;
    end else begin
      add_res.kind           = KIND_ACCEPT;
      add_res.obstacle_index = 5'(box_count);
    end
  end

  // sequencer, table count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      box_count <= '0;
      step      <= '0;
      hit_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_item.action == ACT_ADD) begin
              out_valid <= 1'b1;
              out_item  <= add_res;
              if (!bad_box && box_count < CNT_W'(MAX_OBSTACLES)) begin
                box_count <= box_count + 1'b1;
              end
            end else begin
              state    <= ST_RUN;
              step     <= '0;
              hit_seen <= 1'b0;
            end
          end
        end
        ST_RUN, ST_DRAIN: begin
          if (state == ST_RUN) begin
            step <= step + 1'b1;
            if (step == CNT_W'(MAX_OBSTACLES - 1)) state <= ST_DRAIN;
          end
          if (verdict.hit) begin
            out_valid <= 1'b1;
            hit_seen  <= 1'b1;
            out_item  <= '{kind: KIND_HIT, obstacle_index: 5'(verdict.idx),
                           link_out: link, closest_x: verdict.cx, closest_y: verdict.cy,
                           closest_z: verdict.cz, hit_any: 1'b0, last: 1'b0};
          end else if (state == ST_DRAIN && !busy) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
            out_item  <= '{kind: KIND_DONE, obstacle_index: 5'd0, link_out: link,
                           closest_x: '0, closest_y: '0, closest_z: '0,
                           hit_any: hit_seen, last: 1'b1};
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
